@@ rtl/spibc_pkg.sv @@
// Shared types and constants for the SPI bus byte capture block.
package spibc_pkg;

  // Bus event codes carried on the input request.
  typedef enum logic [1:0] {
    OP_CLOCK  = 2'd0,
    OP_SELECT = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  // Result kinds carried on the output request.
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_DISCARD = 1'b1;

  // Configuration register indexes.
  localparam logic REG_WINDOW_TICKS = 1'b0;
  localparam logic REG_BURST_BYTES  = 1'b1;

  // Register widths and reset values.
  localparam int unsigned WindowW = 16;
  localparam int unsigned BurstW  = 8;
  localparam logic [WindowW-1:0] WindowTicksRst = 16'd100;
  localparam logic [BurstW-1:0]  BurstBytesRst  = 8'd16;

  // Largest partial bit count that can be reported.
  localparam logic [2:0] DiscardMax = 3'd7;

  // Select line events seen since the previous byte.
  typedef struct packed {
    logic final_level;
    logic rose;
    logic fell;
  } sel_flags_t;

  // One result item.
  typedef struct packed {
    logic       kind;
    logic [7:0] mosi_byte;
    logic [7:0] miso_byte;
    logic       select_fell;
    logic       select_rose;
    logic       select_final;
    logic [2:0] bits_discarded;
  } result_t;

endpackage

@@ rtl/spi_bus_byte_capture_top.sv @@
// Top level of the passive SPI bus byte capture block.
//
// Usage: each input request is one bus event. s_axis_tuser selects the event
// (clock rising edge, select line change, time tick) and s_axis_tdata holds
// the sampled MISO, MOSI and select levels. The clock event that completes a
// WORD_BITS-bit word yields one result carrying the assembled MOSI and MISO
// bytes with the select events seen since the previous byte. A tick that ends
// the window while a byte is partly filled yields a discard result with the
// number of dropped bits. Events that cause no result are absorbed silently.
// Each result is registered in the output register before it is presented.
// Throughput: one event per cycle while s_axis_tready is high; every event is
// handled in the cycle it is taken, so the capture state is ready for the next event at once.
// Stalls: results sit in an output register backed by one skid entry. While
// the receiver stalls, input events keep flowing until the skid entry fills,
// then s_axis_tready drops until the output drains.
// Reset: all capture state clears, window_ticks returns to 100 and
// burst_bytes to 16. The configuration port writes one register per cycle;
// the user must write it only while the block is idle; the block does not enforce this.
module spi_bus_byte_capture_top #(
  parameter int unsigned WORD_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  // Input event stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] miso_bit, [1] mosi_bit, [2] select_level
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  // Output result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] mosi_byte, [15:8] miso_byte,
                                      // [16] select_fell, [17] select_rose,
                                      // [18] select_final, [21:19] bits_discarded
  output logic        m_axis_tuser    // [0] kind
);

  localparam int unsigned CntW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [CntW-1:0] LastBit = CntW'(WORD_BITS - 1);

  // Configuration registers.
  logic [spibc_pkg::WindowW-1:0] window_ticks_q;
  logic [spibc_pkg::BurstW-1:0]  burst_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_ticks_q <= spibc_pkg::WindowTicksRst;
      burst_bytes_q  <= spibc_pkg::BurstBytesRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        spibc_pkg::REG_WINDOW_TICKS: window_ticks_q <= cfg_wdata_i;
        spibc_pkg::REG_BURST_BYTES:  burst_bytes_q  <= cfg_wdata_i[spibc_pkg::BurstW-1:0];
        default: ;
      endcase
    end
  end

  // Capture state.
  logic [WORD_BITS-1:0]          miso_shift_q, miso_shift_d;
  logic [WORD_BITS-1:0]          mosi_shift_q, mosi_shift_d;
  logic [CntW-1:0]               bit_count_q, bit_count_d;
  spibc_pkg::sel_flags_t         sel_q, sel_d;
  logic [spibc_pkg::WindowW-1:0] window_count_q, window_count_d;
  logic [spibc_pkg::BurstW-1:0]  burst_count_q, burst_count_d;

  // Output register and skid entry.
  spibc_pkg::result_t out_q, skid_q;
  logic               out_valid_q, skid_valid_q;

  logic               accept;
  logic               res_valid;
  spibc_pkg::result_t res;
  spibc_pkg::op_e     op;
  logic               in_miso, in_mosi, in_level;

  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op            = spibc_pkg::op_e'(s_axis_tuser);
  assign in_miso       = s_axis_tdata[0];
  assign in_mosi       = s_axis_tdata[1];
  assign in_level      = s_axis_tdata[2];

  // Helpers for the event handling below.
  logic [WORD_BITS+7:0]          mosi_ext, miso_ext;
  logic [spibc_pkg::WindowW-1:0] window_next;
  logic [spibc_pkg::BurstW-1:0]  burst_next;
  logic                          expire;

  assign mosi_ext    = {8'd0, mosi_shift_d};
  assign miso_ext    = {8'd0, miso_shift_d};
  assign window_next = window_count_q + 1'b1;
  assign burst_next  = burst_count_q + 1'b1;
  assign expire      = (window_next >= window_ticks_q) || (window_next == '0);

  // Per-event update of the capture state and the result it causes.
  always_comb begin
    miso_shift_d   = miso_shift_q;
    mosi_shift_d   = mosi_shift_q;
    bit_count_d    = bit_count_q;
    sel_d          = sel_q;
    window_count_d = window_count_q;
    burst_count_d  = burst_count_q;
    res_valid      = 1'b0;
    res            = '0;

    if (accept) begin
      case (op)
        spibc_pkg::OP_SELECT: begin
          sel_d.final_level = in_level;
          if (in_level) begin
            sel_d.rose = 1'b1;
          end else begin
            sel_d.fell = 1'b1;
          end
        end
        spibc_pkg::OP_CLOCK: begin
          miso_shift_d = {miso_shift_q[WORD_BITS-2:0], in_miso};
          mosi_shift_d = {mosi_shift_q[WORD_BITS-2:0], in_mosi};
          if (bit_count_q == LastBit) begin
            bit_count_d        = '0;
            res_valid          = 1'b1;
            res.kind           = spibc_pkg::KIND_BYTE;
            res.mosi_byte      = mosi_ext[7:0];
            res.miso_byte      = miso_ext[7:0];
            res.select_fell    = sel_q.fell;
            res.select_rose    = sel_q.rose;
            res.select_final   = sel_q.final_level;
            sel_d              = '0;
            if (burst_next >= burst_bytes_q) begin
              window_count_d = '0;
              burst_count_d  = '0;
            end else begin
              burst_count_d = burst_next;
            end
          end else begin
            bit_count_d = bit_count_q + 1'b1;
          end
        end
        spibc_pkg::OP_TICK: begin
          if (expire) begin
            window_count_d = '0;
            burst_count_d  = '0;
            if (bit_count_q != '0) begin
              res_valid          = 1'b1;
              res.kind           = spibc_pkg::KIND_DISCARD;
              res.bits_discarded = (32'(bit_count_q) > 32'(spibc_pkg::DiscardMax)) ?
                                   spibc_pkg::DiscardMax : 3'(bit_count_q);
              bit_count_d        = '0;
            end
          end else begin
            window_count_d = window_next;
          end
        end
        default: ;
      endcase
    end
  end

  // Capture state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miso_shift_q   <= '0;
      mosi_shift_q   <= '0;
      bit_count_q    <= '0;
      sel_q          <= '0;
      window_count_q <= '0;
      burst_count_q  <= '0;
    end else begin
      miso_shift_q   <= miso_shift_d;
      mosi_shift_q   <= mosi_shift_d;
      bit_count_q    <= bit_count_d;
      sel_q          <= sel_d;
      window_count_q <= window_count_d;
      burst_count_q  <= burst_count_d;
    end
  end

  // Output register with one skid entry behind it.
  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  // Output packing.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {2'b00, out_q.bits_discarded, out_q.select_final,
                          out_q.select_rose, out_q.select_fell,
                          out_q.miso_byte, out_q.mosi_byte};

endmodule
